// ===== sv/mstk_pkg.sv =====
package mstk_pkg;

  // default sizes
  localparam int MAX_NODES_DEF = 16;
  localparam int MAX_EDGES_DEF = 32;
  localparam int COST_BITS_DEF = 16;

  // fixed port widths
  localparam int NODE_W  = 4;
  localparam int PCOST_W = 16;
  localparam int TOTAL_W = 20;
  localparam int CFG_W   = 5;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd16;

  // cell operation codes
  typedef logic [1:0] cell_mode_t;
  localparam cell_mode_t MODE_HOLD = 2'd0;
  localparam cell_mode_t MODE_LOAD = 2'd1;
  localparam cell_mode_t MODE_ROT  = 2'd2;
  localparam cell_mode_t MODE_CLR  = 2'd3;

  typedef struct packed {
    cell_mode_t mode;
    logic       ins_en;
  } cell_ctl_t;

endpackage

// ===== sv/min_spanning_tree_kruskal.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | from_node, to_node, edge_cost, final_edge
// out_    | output    | out_valid/out_stall| tree edge, running total, flags
// cfg_    | input     | cfg_valid/cfg_ready| node_count
//
// Each accepted edge loads into a chain of MAX_EDGES cells that keeps them sorted
// by cost as they arrive. After the final edge the chain is rotated through a
// union-find walk (one cell per cycle at the chain head), then the tree edges are
// emitted in cost order, held by any output stall. Reset is synchronous; in_stall
// is high from the final edge until the last result is in the output register.
module min_spanning_tree_kruskal #(
  parameter int MAX_NODES = mstk_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = mstk_pkg::MAX_EDGES_DEF,
  parameter int COST_BITS = mstk_pkg::COST_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mstk_pkg::NODE_W-1:0]   in_from_node,
  input  logic [mstk_pkg::NODE_W-1:0]   in_to_node,
  input  logic [mstk_pkg::PCOST_W-1:0]  in_edge_cost,
  input  logic                          in_final_edge,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mstk_pkg::NODE_W-1:0]   out_tree_from,
  output logic [mstk_pkg::NODE_W-1:0]   out_tree_to,
  output logic [mstk_pkg::PCOST_W-1:0]  out_tree_cost,
  output logic [mstk_pkg::TOTAL_W-1:0]  out_running_total,
  output logic                          out_edge_present,
  output logic                          out_last_result,
  output logic                          out_dropped_edges,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mstk_pkg::CFG_W-1:0]    cfg_data
);
  import mstk_pkg::*;

  localparam int EW  = $clog2(MAX_EDGES);
  localparam int FW  = EW + 1;
  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = NW + 1;
  localparam int D_W = 2 + 2 * NODE_W + COST_BITS;
  localparam int F_HI = D_W - 3;
  localparam int T_HI = D_W - 3 - NODE_W;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   ncnt_r;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [EW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      acc_r, acc_nxt;
  logic [CW-1:0]      emit_r, emit_nxt;
  logic               drop_r, drop_nxt;
  logic [TOTAL_W-1:0] tot_r, tot_nxt;
  logic [NW-1:0]      lbl_r [MAX_NODES];
  logic [NW-1:0]      lbl_nxt [MAX_NODES];

  logic               ov_r, ov_nxt;
  logic [NODE_W-1:0]  of_r, of_nxt, ot_r, ot_nxt;
  logic [PCOST_W-1:0] oc_r, oc_nxt;
  logic [TOTAL_W-1:0] otot_r, otot_nxt;
  logic               oep_r, oep_nxt, olast_r, olast_nxt, odrop_r, odrop_nxt;

  logic [D_W-1:0] cd   [MAX_EDGES];
  logic           cgt  [MAX_EDGES];
  logic [D_W-1:0] new_d, head_upd;
  cell_ctl_t      ctl;

  logic [CW-1:0]      n_eff;
  logic               in_acc, load_ok, out_free;
  logic [D_W-1:0]     head;
  logic [NODE_W-1:0]  h_f, h_t;
  logic               live, bad, join_e, clr;
  logic [NW-1:0]      la, lb;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !ov_r || !out_stall;

  // effective node count
  always_comb begin
    if (ncnt_r == '0) n_eff = CW'(1);
    else if (int'(ncnt_r) > MAX_NODES) n_eff = CW'(MAX_NODES);
    else n_eff = CW'(ncnt_r);
  end

  assign load_ok = (int'(in_from_node) < int'(n_eff)) && (int'(in_to_node) < int'(n_eff))
                   && (int'(fill_r) < MAX_EDGES);
  assign new_d = {1'b1, 1'b0, in_from_node, in_to_node, COST_BITS'(in_edge_cost)};

  // chain head and union-find decision
  assign head = cd[0];
  assign h_f  = head[F_HI -: NODE_W];
  assign h_t  = head[T_HI -: NODE_W];
  assign bad  = !((int'(h_f) < int'(n_eff)) && (int'(h_t) < int'(n_eff)));
  assign live = (state_r == ST_WALK) && head[D_W-1] && (int'(acc_r) + 1 < int'(n_eff));
  assign la   = lbl_r[NW'(h_f)];
  assign lb   = lbl_r[NW'(h_t)];
  assign join_e = live && !bad && (la != lb);

  always_comb begin
    head_upd = head;
    if (state_r == ST_WALK) head_upd[D_W-2] = join_e;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    emit_nxt  = emit_r;
    drop_nxt  = drop_r;
    tot_nxt   = tot_r;
    lbl_nxt   = lbl_r;
    ctl.mode  = MODE_HOLD;
    ctl.ins_en = 1'b0;
    clr       = 1'b0;
    ov_nxt    = ov_r && out_stall;
    of_nxt    = of_r;
    ot_nxt    = ot_r;
    oc_nxt    = oc_r;
    otot_nxt  = otot_r;
    oep_nxt   = oep_r;
    olast_nxt = olast_r;
    odrop_nxt = odrop_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          ctl.mode   = MODE_LOAD;
          ctl.ins_en = load_ok;
          if (load_ok) fill_nxt = fill_r + FW'(1);
          else drop_nxt = 1'b1;
          if (in_final_edge) begin
            state_nxt = ST_WALK;
            step_nxt  = '0;
          end
        end
      end
      ST_WALK: begin
        ctl.mode = MODE_ROT;
        if (live && bad) drop_nxt = 1'b1;
        if (join_e) begin
          acc_nxt = acc_r + CW'(1);
          for (int k = 0; k < MAX_NODES; k++) begin
            if (lbl_r[k] == lb) lbl_nxt[k] = la;
          end
        end
        step_nxt = step_r + EW'(1);
        if (int'(step_r) == MAX_EDGES - 1) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (acc_r == '0) begin
          if (out_free) begin
            ov_nxt = 1'b1; of_nxt = '0; ot_nxt = '0; oc_nxt = '0; otot_nxt = '0;
            oep_nxt = 1'b0; olast_nxt = 1'b1; odrop_nxt = drop_r;
            clr = 1'b1;
          end
        end else if (head[D_W-1] && head[D_W-2]) begin
          if (out_free) begin
            ctl.mode  = MODE_ROT;
            tot_nxt   = tot_r + TOTAL_W'(head[COST_BITS-1:0]);
            ov_nxt    = 1'b1;
            of_nxt    = h_f;
            ot_nxt    = h_t;
            oc_nxt    = PCOST_W'(head[COST_BITS-1:0]);
            otot_nxt  = tot_nxt;
            oep_nxt   = 1'b1;
            olast_nxt = (emit_r + CW'(1) == acc_r);
            odrop_nxt = drop_r;
            emit_nxt  = emit_r + CW'(1);
            if (emit_r + CW'(1) == acc_r) clr = 1'b1;
          end
        end else begin
          ctl.mode = MODE_ROT;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    // end of run: back to an empty graph
    if (clr) begin
      ctl.mode  = MODE_CLR;
      state_nxt = ST_LOAD;
      fill_nxt  = '0;
      acc_nxt   = '0;
      emit_nxt  = '0;
      drop_nxt  = 1'b0;
      tot_nxt   = '0;
      for (int k = 0; k < MAX_NODES; k++) lbl_nxt[k] = NW'(k);
    end
  end

  // sorted edge chain
  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    mstk_cell #(.COST_BITS(COST_BITS), .D_W(D_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .prev_d  ((i == 0) ? '0 : cd[(i == 0) ? 0 : i - 1]),
      .prev_gt ((i == 0) ? 1'b0 : cgt[(i == 0) ? 0 : i - 1]),
      .next_d  ((i == MAX_EDGES - 1) ? head_upd : cd[(i == MAX_EDGES - 1) ? 0 : i + 1]),
      .new_d   (new_d),
      .d       (cd[i]),
      .gt      (cgt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ncnt_r  <= NODE_COUNT_RST;
      fill_r  <= '0;
      step_r  <= '0;
      acc_r   <= '0;
      emit_r  <= '0;
      drop_r  <= 1'b0;
      tot_r   <= '0;
      ov_r    <= 1'b0;
      for (int k = 0; k < MAX_NODES; k++) lbl_r[k] <= NW'(k);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) ncnt_r <= cfg_data;
      fill_r  <= fill_nxt;
      step_r  <= step_nxt;
      acc_r   <= acc_nxt;
      emit_r  <= emit_nxt;
      drop_r  <= drop_nxt;
      tot_r   <= tot_nxt;
      ov_r    <= ov_nxt;
      lbl_r   <= lbl_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    of_r    <= of_nxt;
    ot_r    <= ot_nxt;
    oc_r    <= oc_nxt;
    otot_r  <= otot_nxt;
    oep_r   <= oep_nxt;
    olast_r <= olast_nxt;
    odrop_r <= odrop_nxt;
  end

  assign out_valid         = ov_r;
  assign out_tree_from     = of_r;
  assign out_tree_to       = ot_r;
  assign out_tree_cost     = oc_r;
  assign out_running_total = otot_r;
  assign out_edge_present  = oep_r;
  assign out_last_result   = olast_r;
  assign out_dropped_edges = odrop_r;

endmodule

// ===== sv/mstk_cell.sv =====
module mstk_cell #(
  parameter int COST_BITS = mstk_pkg::COST_BITS_DEF,
  parameter int D_W       = 2 + 2 * mstk_pkg::NODE_W + COST_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mstk_pkg::cell_ctl_t ctl,
  input  logic [D_W-1:0]      prev_d,
  input  logic                prev_gt,
  input  logic [D_W-1:0]      next_d,
  input  logic [D_W-1:0]      new_d,
  output logic [D_W-1:0]      d,
  output logic                gt
);
  import mstk_pkg::*;

  logic [D_W-1:0] d_r;
  logic [D_W-1:0] d_nxt;

  // this cell lies past the insertion point of the new edge (stable order)
  assign gt = !d_r[D_W-1] || (d_r[COST_BITS-1:0] > new_d[COST_BITS-1:0]);
  assign d  = d_r;

  always_comb begin
    d_nxt = d_r;
    unique case (ctl.mode)
      MODE_LOAD: begin
        if (ctl.ins_en) begin
          if (prev_gt) d_nxt = prev_d;
          else if (gt) d_nxt = new_d;
        end
      end
      MODE_ROT:  d_nxt = next_d;
      MODE_CLR:  d_nxt = '0;
      default:   d_nxt = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_r <= '0;
    else d_r <= d_nxt;
  end

endmodule

// ===== sv/mstk_chk.sv =====
module mstk_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mstk_pkg::NODE_W-1:0]   out_tree_from,
  input logic [mstk_pkg::NODE_W-1:0]   out_tree_to,
  input logic [mstk_pkg::TOTAL_W-1:0]  out_running_total,
  input logic                          out_edge_present,
  input logic                          out_last_result
);
  import mstk_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_running_total))
    else $error("stalled result changed");

  // empty tree result is the single, last one
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_edge_present |-> out_last_result && (out_running_total == '0))
    else $error("bad empty-tree result");

  // a self loop never enters the tree
  a_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_present |-> out_tree_from != out_tree_to)
    else $error("self loop emitted");

  // more results pending keeps the input closed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> in_stall)
    else $error("input open mid-run");

endmodule

bind min_spanning_tree_kruskal mstk_chk u_mstk_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_tree_from     (out_tree_from),
  .out_tree_to       (out_tree_to),
  .out_running_total (out_running_total),
  .out_edge_present  (out_edge_present),
  .out_last_result   (out_last_result)
);

// ===== dv/min_spanning_tree_kruskal_test.sv =====
module min_spanning_tree_kruskal_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mstk_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int EDGES = MAX_EDGES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [NODE_W-1:0]  from_node;
    logic [NODE_W-1:0]  to_node;
    logic [PCOST_W-1:0] edge_cost;
    logic               final_edge;
  } edge_t;

  typedef struct packed {
    logic [NODE_W-1:0]  tree_from;
    logic [NODE_W-1:0]  tree_to;
    logic [PCOST_W-1:0] tree_cost;
    logic [TOTAL_W-1:0] running_total;
    logic               edge_present;
    logic               last_result;
    logic               dropped_edges;
  } tree_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_stall_q;
  edge_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  tree_result_t got;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow of the block's graph state
  logic [CFG_W-1:0]   node_count_q;
  logic [NODE_W-1:0]  sv_from [EDGES];
  logic [NODE_W-1:0]  sv_to   [EDGES];
  logic [PCOST_W-1:0] sv_cost [EDGES];
  int                 fill_cnt;
  logic               drop_seen;
  int                 parent [NODES];
  int                 rnk    [NODES];

  edge_t        pending_edges [$];
  tree_result_t tree_expect   [$];
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  failed = 0;
  int  cycles = 0;

  min_spanning_tree_kruskal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_from_node(in_item.from_node), .in_to_node(in_item.to_node),
    .in_edge_cost(in_item.edge_cost), .in_final_edge(in_item.final_edge),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tree_from(got.tree_from), .out_tree_to(got.tree_to),
    .out_tree_cost(got.tree_cost), .out_running_total(got.running_total),
    .out_edge_present(got.edge_present), .out_last_result(got.last_result),
    .out_dropped_edges(got.dropped_edges),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // queue helpers
  function automatic void add_edge(edge_t e);
    pending_edges.insert(pending_edges.size(), e);
  endfunction

  function automatic void add_expect(tree_result_t r);
    tree_expect.insert(tree_expect.size(), r);
  endfunction

  function automatic int active_nodes();
    if (node_count_q == 0) return 1;
    if (node_count_q > NODES) return NODES;
    return int'(node_count_q);
  endfunction

  function automatic void reset_sets();
    for (int i = 0; i < NODES; i++) begin
      parent[i] = i;
      rnk[i] = 0;
    end
  endfunction

  function automatic int root_of(int v);
    int r, cur, nxt;
    r = v;
    while (parent[r] != r) r = parent[r];
    cur = v;
    while (cur != r) begin
      nxt = parent[cur];
      parent[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  // load one edge; on the final one run Kruskal and queue the tree edges
  function automatic void predict_tree(edge_t e);
    int n, a, b, accepted, k, j;
    int order [EDGES];
    logic [TOTAL_W-1:0] total;
    tree_result_t r;
    int first;
    n = active_nodes();
    accepted = 0;
    total = '0;
    if (e.from_node >= n || e.to_node >= n || fill_cnt >= EDGES) begin
      drop_seen = 1;
    end else begin
      sv_from[fill_cnt] = e.from_node;
      sv_to[fill_cnt] = e.to_node;
      sv_cost[fill_cnt] = e.edge_cost;
      fill_cnt++;
    end
    if (!e.final_edge) return;
    // stable insertion sort by cost
    for (int i = 0; i < fill_cnt; i++) begin
      j = i;
      while (j > 0 && sv_cost[order[j-1]] > sv_cost[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    reset_sets();
    first = tree_expect.size();
    for (int i = 0; i < fill_cnt && accepted + 1 < n; i++) begin
      k = order[i];
      if (sv_from[k] >= n || sv_to[k] >= n) begin
        drop_seen = 1;
        continue;
      end
      a = root_of(sv_from[k]);
      b = root_of(sv_to[k]);
      if (a != b) begin
        if (rnk[a] < rnk[b]) parent[a] = b;
        else if (rnk[a] > rnk[b]) parent[b] = a;
        else begin
          parent[b] = a;
          if (rnk[a] < 7) rnk[a]++;
        end
        total = total + sv_cost[k];
        r = '{sv_from[k], sv_to[k], sv_cost[k], total, 1'b1, 1'b0, 1'b0};
        add_expect(r);
        accepted++;
      end
    end
    if (accepted == 0) add_expect('0);
    tree_expect[tree_expect.size()-1].last_result = 1;
    for (int i = first; i < tree_expect.size(); i++)
      tree_expect[i].dropped_edges = drop_seen;
    fill_cnt = 0;
    drop_seen = 0;
    reset_sets();
  endfunction

  // driver: presents queued edges, changes at falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        // accepted at last rising edge; pick next or idle
        if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_edges.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end else if (!in_valid) begin
        if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_edges.pop_front();
          in_valid <= 1;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // stall as sampled at the rising edge the driver is reacting to
  always @(posedge clk) in_stall_q <= in_stall;

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (cfg_valid && cfg_ready) node_count_q = cfg_data;
      if (in_valid && !in_stall) predict_tree(in_item);
      if (out_valid && !out_stall) begin
        if (tree_expect.size() == 0) begin
          $error("unexpected tree result");
          failed = 1;
        end else begin
          tree_result_t x;
          x = tree_expect.pop_front();
          if (got.tree_from !== x.tree_from) begin
            $error("tree_from exp %0d got %0d", x.tree_from, got.tree_from); failed = 1;
          end
          if (got.tree_to !== x.tree_to) begin
            $error("tree_to exp %0d got %0d", x.tree_to, got.tree_to); failed = 1;
          end
          if (got.tree_cost !== x.tree_cost) begin
            $error("tree_cost exp %0d got %0d", x.tree_cost, got.tree_cost); failed = 1;
          end
          if (got.running_total !== x.running_total) begin
            $error("running_total exp %0d got %0d", x.running_total, got.running_total);
            failed = 1;
          end
          if (got.edge_present !== x.edge_present) begin
            $error("edge_present exp %0d got %0d", x.edge_present, got.edge_present);
            failed = 1;
          end
          if (got.last_result !== x.last_result) begin
            $error("last_result exp %0d got %0d", x.last_result, got.last_result);
            failed = 1;
          end
          if (got.dropped_edges !== x.dropped_edges) begin
            $error("dropped_edges exp %0d got %0d", x.dropped_edges, got.dropped_edges);
            failed = 1;
          end
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic edge_t rand_edge(int n, bit fin);
    edge_t e;
    int hi;
    hi = ($urandom_range(9) == 0) ? 15 : n - 1;
    e.from_node = NODE_W'($urandom_range(hi));
    e.to_node = NODE_W'($urandom_range(hi));
    case ($urandom_range(3))
      0: e.edge_cost = PCOST_W'($urandom_range(7));
      1: e.edge_cost = PCOST_W'(16'hFFFF - $urandom_range(3));
      default: e.edge_cost = PCOST_W'($urandom);
    endcase
    e.final_edge = fin;
    return e;
  endfunction

  // queue one graph of len edges, last one final
  task automatic queue_graph(int len);
    int n;
    n = active_nodes();
    for (int i = 0; i < len; i++) add_edge(rand_edge(n, i == len - 1));
  endtask

  task automatic wait_drained();
    while (pending_edges.size() > 0 || in_valid || tree_expect.size() > 0)
      @(posedge clk);
    repeat (2 * EDGES + 20) @(posedge clk);
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  int sent;
  int len;
  initial begin
    node_count_q = NODE_COUNT_RST;
    fill_cnt = 0;
    drop_seen = 0;
    reset_sets();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: empty tree, self-loop, extremes, bad endpoint, ties
    add_edge('{4'd3, 4'd3, 16'd5, 1'b1});
    add_edge('{4'd0, 4'd15, 16'hFFFF, 1'b0});
    add_edge('{4'd15, 4'd0, 16'hFFFF, 1'b0});
    add_edge('{4'd1, 4'd2, 16'd0, 1'b0});
    add_edge('{4'd2, 4'd1, 16'd0, 1'b1});
    wait_drained();
    write_node_count(5'd4);
    add_edge('{4'd0, 4'd9, 16'd1, 1'b0});
    add_edge('{4'd0, 4'd1, 16'd3, 1'b0});
    add_edge('{4'd1, 4'd2, 16'd3, 1'b0});
    add_edge('{4'd2, 4'd3, 16'd3, 1'b0});
    add_edge('{4'd0, 4'd3, 16'd1, 1'b1});
    wait_drained();
    // store overflow at full node count
    write_node_count(5'd16);
    queue_graph(EDGES + 3);
    wait_drained();
    write_node_count(5'd0);
    add_edge('{4'd0, 4'd0, 16'd7, 1'b1});
    wait_drained();
    write_node_count(5'd31);
    queue_graph(4);
    wait_drained();
    // node_count change between load and compute
    queue_graph(6);
    pending_edges.pop_back();
    wait_drained();
    write_node_count(5'd3);
    add_edge('{4'd1, 4'd2, 16'd9, 1'b1});
    wait_drained();

    // random phases
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 36 : 0;
      while (sent < 100 * (ph + 1)) begin
        if ($urandom_range(3) == 0) begin
          wait_drained();
          case ($urandom_range(3))
            0: write_node_count(5'd1);
            1: write_node_count(5'd16);
            default: write_node_count(CFG_W'($urandom_range(2, 16)));
          endcase
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(20, EDGES + 2) : $urandom_range(1, 10);
        queue_graph(len);
        sent += len;
      end
      wait_drained();
    end

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
